### rtl/core/sfr_pkg.sv
package sfr_pkg;

  localparam int WINDOW_MAX_DEF = 8;
  localparam int BURST_MAX      = 8;
  localparam int BCNT_W         = 4;
  localparam int LEN_W          = 4;
  localparam int TEXT_W         = 64;
  localparam int ADDR_W         = 2;

  typedef enum logic [ADDR_W-1:0] {
    REG_FIND_TEXT    = 2'd0,
    REG_FIND_LEN     = 2'd1,
    REG_REPLACE_TEXT = 2'd2,
    REG_REPLACE_LEN  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [TEXT_W-1:0] find_text;
    logic [LEN_W-1:0]  find_len;
    logic [TEXT_W-1:0] replace_text;
    logic [LEN_W-1:0]  replace_len;
  } cfg_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [BCNT_W-1:0]         cnt;
    logic                      marker;
    logic                      last;
  } burst_t;

endpackage

### rtl/core/sfr_window.sv
module sfr_window
  import sfr_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  cfg_t       cfg,
  input  logic       flush_win,
  input  logic       take,
  output logic       burst_vld,
  output burst_t     burst
);

  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic                       vld_r;
  logic [7:0]                 byte_r;
  logic                       last_r;
  logic [WINDOW_MAX-1:0][7:0] win_r;
  logic [WINDOW_MAX-1:0][7:0] win_nxt;
  logic [WINDOW_MAX-1:0][7:0] wn;
  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              cnt_nxt;
  logic [CW-1:0]              cnt_app;
  logic                       full;
  logic                       match;
  logic [BCNT_W-1:0]          n;
  logic                       load;

  assign load      = vld_r && take;
  assign in_ready  = !vld_r || take;
  assign burst_vld = vld_r;

  always_comb begin
    wn      = win_r;
    cnt_app = cnt_r;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (CW'(i) == cnt_r) begin
        wn[i] = byte_r;
      end
    end
    if (cnt_r < CW'(WINDOW_MAX)) begin
      cnt_app = cnt_r + 1'b1;
    end
    full  = LEN_W'(cnt_app) >= cfg.find_len;
    match = full;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if ((LEN_W'(i) < cfg.find_len) && (wn[i] != cfg.find_text[8*i +: 8])) begin
        match = 1'b0;
      end
    end

    burst.bytes = '0;
    win_nxt     = wn;
    cnt_nxt     = cnt_app;
    if (match) begin
      burst.bytes = cfg.replace_text;
      n           = cfg.replace_len;
      cnt_nxt     = '0;
    end else begin
      for (int j = 0; j < WINDOW_MAX; j++) begin
        burst.bytes[j] = wn[j];
      end
      if (last_r) begin
        n = BCNT_W'(cnt_app);
      end else if (full) begin
        n = BCNT_W'(1);
      end else begin
        n = '0;
      end
      if (full) begin
        for (int i = 0; i < WINDOW_MAX - 1; i++) begin
          win_nxt[i] = wn[i+1];
        end
        cnt_nxt = cnt_app - 1'b1;
      end
    end
    if (last_r) begin
      cnt_nxt = '0;
    end
    burst.marker = last_r && (n == '0);
    burst.cnt    = burst.marker ? BCNT_W'(1) : n;
    burst.last   = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (load) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (flush_win) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win_r <= win_nxt;
    end
  end

  // Between items the window always holds fewer bytes than one pattern.
  a_win_short: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(cnt_r) < cfg.find_len)
    else $error("window holds a full pattern between items");

endmodule

### rtl/core/sfr_burst.sv
module sfr_burst
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       burst_vld,
  input  burst_t     burst,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_end,
  output logic       stream_end
);

  logic [BURST_MAX-1:0][7:0] bytes_r;
  logic [BCNT_W-1:0]         cnt_r;
  logic                      marker_r;
  logic                      last_r;
  logic                      load;

  assign take       = (cnt_r == '0) || ((cnt_r == BCNT_W'(1)) && out_ready);
  assign load       = burst_vld && take;
  assign out_valid  = cnt_r != '0;
  assign out_byte   = marker_r ? 8'h00 : bytes_r[0];
  assign byte_valid = !marker_r;
  assign run_end    = cnt_r == BCNT_W'(1);
  assign stream_end = run_end && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.cnt;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r  <= burst.bytes;
      marker_r <= burst.marker;
      last_r   <= burst.last;
    end else if (out_valid && out_ready) begin
      bytes_r <= {8'h00, bytes_r[BURST_MAX-1:1]};
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && (burst.cnt != '0) |=> out_valid)
    else $error("loaded run is not presented");

  a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && marker_r |-> cnt_r == BCNT_W'(1))
    else $error("end marker is not a single item");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= BCNT_W'(BURST_MAX))
    else $error("run length exceeds buffer");

endmodule

### rtl/core/stream_find_replace_unit.sv
// Streaming byte find-and-replace.
// Input channel: one text byte per item on in_tdata, in_tlast marks the end of the text.
// Result channel: one byte per item on out_tdata; out_tlast marks the last item caused by
// one input item, out_tuser[0] says the item carries a byte (0 is an empty end marker),
// out_tuser[1] marks the final item of the whole text.
// Configuration: cfg_we writes register cfg_addr (0 find text, 1 find length,
// 2 replacement text, 3 replacement length) with cfg_wdata; a find length write
// drops any pending bytes. Write only while the block is idle.
// An input item is held in the input register, where its results are built, and is loaded
// into the output buffer once that buffer can take it; the buffer then presents its first result.
// One input item per cycle is sustained while each item yields at most one result and
// out_tready stays high; an item that yields n results holds the output buffer until all n
// are taken, one result per cycle while out_tready is high.
// The output buffer is reloaded in the cycle its last result is taken, so input stalls
// only while a run drains or out_tready is low; a stalled result holds its value.
// Reset clears the pending window, both stages and the registers (find length 1).
module stream_find_replace_unit
  import sfr_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_byte
  output logic [1:0]        out_tuser,  // [0] byte_valid, [1] stream_end
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [TEXT_W-1:0] cfg_wdata
);

  logic [TEXT_W-1:0] find_text_r;
  logic [LEN_W-1:0]  find_len_r;
  logic [TEXT_W-1:0] replace_text_r;
  logic [LEN_W-1:0]  replace_len_r;
  logic              flush_win;
  cfg_t              cfg;
  logic              take;
  logic              burst_vld;
  burst_t            burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      find_text_r    <= '0;
      find_len_r     <= LEN_W'(1);
      replace_text_r <= '0;
      replace_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FIND_TEXT:    find_text_r    <= cfg_wdata;
        REG_FIND_LEN:     find_len_r     <= cfg_wdata[LEN_W-1:0];
        REG_REPLACE_TEXT: replace_text_r <= cfg_wdata;
        REG_REPLACE_LEN:  replace_len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign flush_win = cfg_we && (cfg_reg_t'(cfg_addr) == REG_FIND_LEN);

  always_comb begin
    cfg.find_text    = find_text_r;
    cfg.replace_text = replace_text_r;
    if (find_len_r == '0) begin
      cfg.find_len = LEN_W'(1);
    end else if (find_len_r > LEN_W'(WINDOW_MAX)) begin
      cfg.find_len = LEN_W'(WINDOW_MAX);
    end else begin
      cfg.find_len = find_len_r;
    end
    if (replace_len_r > LEN_W'(BURST_MAX)) begin
      cfg.replace_len = LEN_W'(BURST_MAX);
    end else begin
      cfg.replace_len = replace_len_r;
    end
  end

  sfr_window #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .cfg       (cfg),
    .flush_win (flush_win),
    .take      (take),
    .burst_vld (burst_vld),
    .burst     (burst)
  );

  sfr_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst_vld  (burst_vld),
    .burst      (burst),
    .take       (take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .byte_valid (out_tuser[0]),
    .run_end    (out_tlast),
    .stream_end (out_tuser[1])
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int QUIET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_end;
    logic       stream_end;
  } text_out_t;

  class rewrite_scoreboard;
    logic [TEXT_W-1:0] find_text    = '0;
    logic [LEN_W-1:0]  find_len     = 4'd1;
    logic [TEXT_W-1:0] replace_text = '0;
    logic [LEN_W-1:0]  replace_len  = '0;
    logic [7:0]        window [WINDOW_MAX_DEF];
    int                window_count = 0;
    text_out_t         pending_text [$];
    int                failures     = 0;

    function int pending();
      return pending_text.size();
    endfunction

    function void write_reg(cfg_reg_t addr, logic [TEXT_W-1:0] value);
      case (addr)
        REG_FIND_TEXT: find_text = value;
        REG_FIND_LEN: begin
          find_len = value[LEN_W-1:0];
          window_count = 0;
        end
        REG_REPLACE_TEXT: replace_text = value;
        REG_REPLACE_LEN: replace_len = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      text_out_t run [$];
      text_out_t item;
      int flen;
      int rlen;
      bit hit;
      flen = int'(find_len);
      if (flen == 0) flen = 1;
      if (flen > WINDOW_MAX_DEF) flen = WINDOW_MAX_DEF;
      rlen = int'(replace_len);
      if (rlen > BURST_MAX) rlen = BURST_MAX;
      if (window_count < WINDOW_MAX_DEF) begin
        window[window_count] = b;
        window_count++;
      end
      if (window_count >= flen) begin
        hit = 1'b1;
        for (int i = 0; i < flen; i++)
          if (window[i] != find_text[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++)
            run.push_back(text_out_t'{replace_text[8*i +: 8], 1'b1, 1'b0, 1'b0});
          window_count = 0;
        end else begin
          run.push_back(text_out_t'{window[0], 1'b1, 1'b0, 1'b0});
          for (int i = 0; i < WINDOW_MAX_DEF - 1; i++) window[i] = window[i+1];
          window_count--;
        end
      end
      if (last) begin
        for (int i = 0; i < window_count; i++)
          run.push_back(text_out_t'{window[i], 1'b1, 1'b0, 1'b0});
        window_count = 0;
        if (run.size() == 0) run.push_back(text_out_t'{8'h00, 1'b0, 1'b0, 1'b0});
      end
      foreach (run[i]) begin
        item = run[i];
        item.run_end = (i == run.size() - 1);
        item.stream_end = last && (i == run.size() - 1);
        pending_text.push_back(item);
      end
    endfunction

    function void check_result(text_out_t got);
      text_out_t want;
      if (pending_text.size() == 0) begin
        if (failures < 10)
          $display("unexpected result: byte %02h valid %0b run_end %0b stream_end %0b",
                   got.data, got.byte_valid, got.run_end, got.stream_end);
        failures++;
      end else begin
        want = pending_text.pop_front();
        if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
            got.run_end !== want.run_end || got.stream_end !== want.stream_end) begin
          if (failures < 10)
            $display("mismatch: expected byte %02h valid %0b run_end %0b stream_end %0b, %s",
                     want.data, want.byte_valid, want.run_end, want.stream_end,
                     $sformatf("got byte %02h valid %0b run_end %0b stream_end %0b",
                               got.data, got.byte_valid, got.run_end, got.stream_end));
          failures++;
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_addr;
  logic [TEXT_W-1:0] cfg_wdata;

  rewrite_scoreboard sb = new;
  int cycles     = 0;
  int burst_left = 0;
  bit no_gaps    = 1'b0;
  bit hold_req   = 1'b0;

  stream_find_replace_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        sb.check_result(text_out_t'{out_tdata, out_tuser[0], out_tlast, out_tuser[1]});
    end
  end

  initial begin : receiver
    int style;
    int span;
    style = 0;
    span = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span = $urandom_range(16, 80);
        end
        span--;
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (cycles % 5) < 3;
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_text(logic [7:0] b, logic last);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t addr, logic [TEXT_W-1:0] value);
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(addr, value);
  endtask

  task automatic write_settings(logic [63:0] ftext, logic [63:0] flen,
                                logic [63:0] rtext, logic [63:0] rlen);
    cfg_we <= 1'b1;
    put_reg(REG_FIND_TEXT, ftext);
    put_reg(REG_FIND_LEN, flen);
    put_reg(REG_REPLACE_TEXT, rtext);
    put_reg(REG_REPLACE_LEN, rlen);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    logic [63:0] junk;
    logic [63:0] rtext;
    junk = {$urandom, $urandom};
    rtext = {$urandom, $urandom};
    // Reset settings delete every zero byte, so a text whose last byte leaves nothing ends in an empty marker.
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b1);
    wait_idle();
    write_settings({junk[63:16], 16'h6261}, {junk[63:4], 4'd2},
                   {rtext[63:24], 24'h5A5958}, 64'd3);
    send_text(8'h61, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h78, 1'b0);
    send_text(8'h61, 1'b1);
    wait_idle();
    // A zero find length acts as one, and a replacement length above eight saturates.
    write_settings({56'hFF_FFFF_FFFF_FFFF, 8'h41}, 64'd0, rtext, {junk[63:4], 4'd12});
    send_text(8'h41, 1'b0);
    send_text(8'h42, 1'b1);
    wait_idle();
    // A find length above the window saturates, and a deleted match at the end leaves a marker.
    write_settings(junk, {rtext[63:4], 4'd15}, rtext, 64'd0);
    for (int i = 0; i < 8; i++) send_text(junk[8*i +: 8], i == 7);
    for (int i = 0; i < 3; i++) send_text(junk[8*i +: 8], 1'b0);
    wait_idle();
    // The three pending bytes are dropped by the find length write.
    write_settings(junk, 64'd2, rtext, 64'd1);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic run_phase(int idx);
    logic [7:0]  alpha [4];
    logic [63:0] ftext;
    logic [63:0] rtext;
    logic [63:0] fword;
    logic [63:0] rword;
    logic [7:0]  b;
    logic        last;
    int          flen;
    int          n;
    int          chunk;
    int          pick;
    for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom);
    fword = {$urandom, $urandom};
    rword = {$urandom, $urandom};
    case (idx)
      0: begin
        fword[3:0] = 4'd8;
        rword[3:0] = 4'd8;
      end
      1: begin
        fword[3:0] = 4'd1;
        rword[3:0] = 4'd0;
      end
      default: begin
        fword[3:0] = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
        rword[3:0] = 4'($urandom);
      end
    endcase
    flen = int'(fword[3:0]);
    if (flen == 0) flen = 1;
    if (flen > WINDOW_MAX_DEF) flen = WINDOW_MAX_DEF;
    ftext = {$urandom, $urandom};
    for (int i = 0; i < flen; i++) ftext[8*i +: 8] = alpha[$urandom_range(0, 3)];
    rtext = {$urandom, $urandom};
    write_settings(ftext, fword, rtext, rword);
    no_gaps = (idx % 4 == 2) || (idx == 3);
    if (idx == 3) hold_req = 1'b1;
    n = 0;
    while (n < PHASE_ITEMS) begin
      pick = $urandom_range(0, 9);
      chunk = (pick < 4) ? flen : (pick < 5) ? int'($urandom_range(1, flen)) : 1;
      for (int i = 0; i < chunk && n < PHASE_ITEMS; i++) begin
        if (pick < 5) b = ftext[8*i +: 8];
        else if (pick < 9) b = alpha[$urandom_range(0, 3)];
        else b = 8'($urandom);
        n++;
        last = (n == PHASE_ITEMS) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
        send_text(b, last);
      end
    end
    wait_idle();
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_FIND_TEXT;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < PHASES; p++) run_phase(p);
    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
